// ===== src/emrp_pkg.sv =====
// Shared types and constants of the extent map read planner.
package emrp_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned START_W = 39;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned SRC_W   = 40;
  localparam int unsigned LAYER_W = 8;
  localparam int unsigned OFS_W   = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned DEST_W  = 23;
  localparam int unsigned PLEN_W  = 24;
  localparam int unsigned VSZ_W   = 48;

  typedef enum logic [1:0] {
    OP_INVALIDATE = 2'd0,
    OP_NEW_TABLE  = 2'd1,
    OP_APPEND     = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ZERO   = 2'd0,
    KIND_SOURCE = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_INVALID    = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [START_W-1:0] extent_start;
    logic [LEN_W-1:0]   extent_length;
    logic [SRC_W-1:0]   extent_source;
    logic [LAYER_W-1:0] extent_layer;
    logic               extent_is_zero;
    logic [OFS_W-1:0]   read_offset;
    logic [CNT_W-1:0]   read_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]         piece_kind;
    logic [DEST_W-1:0]  dest_sector;
    logic [PLEN_W-1:0]  piece_sectors;
    logic [LAYER_W-1:0] src_layer;
    logic [SRC_W-1:0]   src_sector;
    logic [1:0]         status;
    logic [CNT_W-1:0]   total_bytes;
    logic               last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request, run checks
    logic prep;    // compute sector bounds
    logic fetch;   // read entry at iterator
    logic step;    // evaluate one walk step
  } cmd_t;

  // datapath -> controller
  typedef enum logic [2:0] {
    CHK_SIMPLE = 3'd0, // single status result, already built
    CHK_WALK   = 3'd1  // read needs a table walk
  } chk_t;

  typedef struct packed {
    logic chk_walk;   // after load: walk needed
    logic emit;       // after step: a result was built (piece or final status)
    logic done;       // after step: walk is over
  } sts_t;

endpackage

// ===== src/emrp_if.sv =====
// Valid/ready channel carrying one payload.
interface emrp_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/extent_map_read_planner.sv =====
// Top level of the extent map read planner.
// A request answered by one status result is built in the datapath result register and
// moves to the output register from state CHECK; the next request is taken back in IDLE.
// A walked read repeats steps (each step is a fetch and an evaluate) until its final result,
// with at most MAX_EXTENTS + results + 1 steps, plus stalls at the output.
// One request at a time. Reset: rst_n synchronous; table invalid, size 0.
module extent_map_read_planner #(
  parameter int unsigned MAX_EXTENTS  = 16,
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [emrp_pkg::VSZ_W-1:0] cfg_wdata,
  emrp_if.sink                       in_ch,
  emrp_if.source                     out_ch
);
  import emrp_pkg::*;

  logic [VSZ_W-1:0] vsize_r;
  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic in_ready, out_load, out_valid_r, out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) vsize_r <= '0;
    else if (cfg_we) vsize_r <= cfg_wdata;
  end

  // output register; free when empty or being taken
  assign out_free = !out_valid_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end
  res_t out_r;
  always_ff @(posedge clk) if (out_load) out_r <= res;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  emrp_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire (in_ch.valid && in_ready),
    .out_free, .sts, .cmd, .in_ready, .out_load
  );

  emrp_dp #(.MAX_EXTENTS(MAX_EXTENTS), .SECTOR_BYTES(SECTOR_BYTES)) u_dp (
    .clk, .rst_n, .cmd, .req(in_ch.data), .vsize(vsize_r), .sts, .res
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready) else $error("request taken during walk");
  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r) else $error("result lost");
`endif
endmodule

// ===== src/emrp_ctrl.sv =====
// Controller state machine of the read planner.
module emrp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            out_free,
  input  emrp_pkg::sts_t  sts,
  output emrp_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            out_load
);
  import emrp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_PREP  = 6'b000100,
    S_FETCH = 6'b001000,
    S_STEP  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_done_r, pend_done_nxt;

  always_comb begin
    state_nxt     = state_r;
    pend_done_nxt = pend_done_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.chk_walk) begin
          state_nxt = S_PREP;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step      = 1'b1;
        pend_done_nxt = sts.done;
        if (sts.emit) state_nxt = S_EMIT;
        else if (sts.done) state_nxt = S_EMIT;
        else state_nxt = S_FETCH;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = pend_done_r ? S_IDLE : S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_done_r <= pend_done_nxt;
    end
  end
endmodule

// ===== src/emrp_dp.sv =====
// Datapath: extent table, request checks and the walk step.
module emrp_dp #(
  parameter int unsigned MAX_EXTENTS  = 16,
  parameter int unsigned SECTOR_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  emrp_pkg::cmd_t                cmd,
  input  emrp_pkg::req_t                req,
  input  logic [emrp_pkg::VSZ_W-1:0]    vsize,
  output emrp_pkg::sts_t                sts,
  output emrp_pkg::res_t                res
);
  import emrp_pkg::*;

  localparam int unsigned SB = $clog2(SECTOR_BYTES);
  localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned UW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned EW = START_W + 1;    // extent end
  // sector numbers: request end incl. carry, or extent end, whichever is wider
  localparam int unsigned SW = (OFS_W - SB + 1 > EW) ? OFS_W - SB + 1 : EW;

  logic [START_W-1:0] t_start  [MAX_EXTENTS];
  logic [LEN_W-1:0]   t_len    [MAX_EXTENTS];
  logic [SRC_W-1:0]   t_src    [MAX_EXTENTS];
  logic [LAYER_W-1:0] t_layer  [MAX_EXTENTS];
  logic               t_zero   [MAX_EXTENTS];

  logic [UW-1:0] used_r;
  logic          valid_r;
  logic [UW-1:0] it_r, it_nxt;
  logic          seek_r, seek_nxt;   // skipping to first entry past start
  logic [SW-1:0] start_r, end_r, cur_r, cur_nxt;
  logic [OFS_W-1:0] offs_r;
  logic [CNT_W-1:0] cnt_r;
  logic          walk_r;
  res_t          res_r;

  // registered entry read
  logic [START_W-1:0] e_start_r;
  logic [LEN_W-1:0]   e_len_r;
  logic [SRC_W-1:0]   e_src_r;
  logic [LAYER_W-1:0] e_layer_r;
  logic               e_zero_r;
  logic               e_ok_r;

  logic [IW-1:0] wr_idx, rd_idx;
  assign wr_idx = used_r[IW-1:0];
  assign rd_idx = it_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && req.op == OP_APPEND && valid_r && used_r < UW'(MAX_EXTENTS)) begin
      t_start[wr_idx] <= req.extent_start;
      t_len[wr_idx]   <= req.extent_length;
      t_src[wr_idx]   <= req.extent_source;
      t_layer[wr_idx] <= req.extent_layer;
      t_zero[wr_idx]  <= req.extent_is_zero;
    end
    if (cmd.fetch) begin
      e_start_r <= t_start[rd_idx];
      e_len_r   <= t_len[rd_idx];
      e_src_r   <= t_src[rd_idx];
      e_layer_r <= t_layer[rd_idx];
      e_zero_r  <= t_zero[rd_idx];
      e_ok_r    <= it_r < used_r;
    end
  end

  // load checks
  logic          misal, beyond;
  logic [OFS_W:0] room, cnt_clip;
  res_t          load_res;
  always_comb begin
    misal    = (req.read_offset[SB-1:0] != '0) || (req.read_bytes[SB-1:0] != '0);
    beyond   = req.read_offset >= vsize;
    room     = {1'b0, vsize} - {1'b0, req.read_offset};
    cnt_clip = ({17'd0, req.read_bytes} > room) ? room : {17'd0, req.read_bytes};
    load_res            = '0;
    load_res.piece_kind = KIND_STATUS;
    load_res.last       = 1'b1;
    unique case (op_t'(req.op))
      OP_APPEND: load_res.status = !valid_r ? ST_INVALID :
                   (used_r >= UW'(MAX_EXTENTS)) ? ST_FULL : ST_OK;
      OP_READ: load_res.status = misal ? ST_MISALIGNED :
                 (beyond || cnt_clip == '0) ? ST_OK :
                 !valid_r ? ST_INVALID : ST_OK;
      default: load_res.status = ST_OK;
    endcase
  end

  // walk step; whether a piece is the final one is known when it is built
  logic [EW-1:0]  e_end;
  logic [SW-1:0]  s_w, e_w, to_w;
  logic           hit_end, gap, past;
  res_t           piece;
  logic           emit, done;
  always_comb begin
    e_end   = {1'b0, e_start_r} + EW'(e_len_r);
    s_w     = SW'(e_start_r);
    e_w     = SW'(e_end);
    to_w    = (e_w < end_r) ? e_w : end_r;
    hit_end = !e_ok_r || s_w >= end_r;
    gap     = s_w > cur_r;
    past    = e_w <= cur_r;
    piece   = '0;
    piece.dest_sector = DEST_W'(cur_r - start_r);
    emit    = 1'b0;
    done    = 1'b0;
    cur_nxt = cur_r;
    it_nxt  = it_r;
    seek_nxt = seek_r;
    if (seek_r) begin
      if (e_ok_r && e_w <= start_r) it_nxt = it_r + 1'b1;
      else seek_nxt = 1'b0;
    end else if (cur_r >= end_r) begin
      done = 1'b1; // no whole sector to plan
    end else if (hit_end) begin
      piece.piece_kind    = KIND_ZERO;
      piece.piece_sectors = PLEN_W'(end_r - cur_r);
      emit = 1'b1;
      done = 1'b1;
      cur_nxt = end_r;
    end else if (gap) begin
      piece.piece_kind    = KIND_ZERO;
      piece.piece_sectors = PLEN_W'(s_w - cur_r);
      emit = 1'b1;
      cur_nxt = s_w;
    end else if (past) begin
      it_nxt = it_r + 1'b1;
    end else begin
      piece.piece_sectors = PLEN_W'(to_w - cur_r);
      if (e_zero_r) piece.piece_kind = KIND_ZERO;
      else begin
        piece.piece_kind = KIND_SOURCE;
        piece.src_layer  = e_layer_r;
        piece.src_sector = e_src_r + SRC_W'(cur_r - s_w);
      end
      emit = 1'b1;
      cur_nxt = to_w;
      if (e_w <= to_w) it_nxt = it_r + 1'b1;
      done = (to_w >= end_r);
    end
    if (done) begin
      piece.last        = 1'b1;
      piece.total_bytes = cnt_r;
      if (!emit) begin
        piece.piece_kind  = KIND_STATUS;
        piece.dest_sector = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      valid_r <= 1'b0;
      walk_r  <= 1'b0;
    end else if (cmd.load) begin
      unique case (op_t'(req.op))
        OP_INVALIDATE: begin valid_r <= 1'b0; used_r <= '0; end
        OP_NEW_TABLE:  begin valid_r <= 1'b1; used_r <= '0; end
        OP_APPEND: if (valid_r && used_r < UW'(MAX_EXTENTS)) used_r <= used_r + 1'b1;
        OP_READ: ;
        default: ;
      endcase
      walk_r <= req.op == OP_READ && !misal && !beyond && cnt_clip != '0 && valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r  <= load_res;
      offs_r <= req.read_offset;
      cnt_r  <= CNT_W'(cnt_clip);
    end else if (cmd.step && (emit || done)) begin
      res_r <= piece;
    end
    if (cmd.prep) begin
      start_r <= SW'(offs_r >> SB);
      end_r   <= SW'(({1'b0, offs_r} + (OFS_W+1)'(cnt_r)) >> SB);
      cur_r   <= SW'(offs_r >> SB);
      it_r    <= '0;
      seek_r  <= 1'b1;
    end
    if (cmd.step) begin
      cur_r  <= cur_nxt;
      it_r   <= it_nxt;
      seek_r <= seek_nxt;
    end
  end

  // every step that builds a result hands it to the output
  assign sts.chk_walk = walk_r;
  assign sts.emit     = emit || done;
  assign sts.done     = done;

  assign res = res_r;
endmodule

// ===== test/tb.sv =====
// Self-checking bench for the extent map read planner.
module tb;
  import emrp_pkg::*;

  localparam int unsigned NEXT = 16;
  localparam int unsigned SECB = 512;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [VSZ_W-1:0] cfg_wdata;

  emrp_if #(.T(req_t)) req_ch ();
  emrp_if #(.T(res_t)) res_ch ();

  extent_map_read_planner #(.MAX_EXTENTS(NEXT), .SECTOR_BYTES(SECB)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch.sink),
    .out_ch    (res_ch.source)
  );

  // Planner model and queue of pieces still to come.
  class plan_board;
    logic [START_W-1:0] ext_start [NEXT];
    logic [LEN_W-1:0]   ext_len   [NEXT];
    logic [SRC_W-1:0]   ext_src   [NEXT];
    logic [LAYER_W-1:0] ext_layer [NEXT];
    logic               ext_zero  [NEXT];
    int unsigned        used;
    bit                 valid;
    logic [VSZ_W-1:0]   vsize;
    res_t               pending [$];
    int                 errors;

    function void clear();
      used = 0;
      valid = 0;
      vsize = '0;
      pending.delete();
      errors = 0;
    endfunction

    function void add_piece(kind_t k, longint unsigned dest, longint unsigned len,
                            logic [LAYER_W-1:0] lay, logic [SRC_W-1:0] src);
      res_t r;
      r = '0;
      r.piece_kind = k;
      r.dest_sector = dest[DEST_W-1:0];
      r.piece_sectors = len[PLEN_W-1:0];
      r.src_layer = lay;
      r.src_sector = src;
      r.status = ST_OK;
      pending.insert(pending.size(), r);
    endfunction

    function void add_status(status_t st, logic [CNT_W-1:0] total);
      res_t r;
      r = '0;
      r.piece_kind = KIND_STATUS;
      r.status = st;
      r.total_bytes = total;
      r.last = 1'b1;
      pending.insert(pending.size(), r);
    endfunction

    // Note an accepted request and queue what it should produce.
    function void note_request(req_t q);
      longint unsigned ofs, cnt, ssec, esec, cur, s, e, upto;
      int unsigned it;
      int npieces;
      case (op_t'(q.op))
        OP_INVALIDATE: begin
          valid = 0; used = 0; add_status(ST_OK, '0);
        end
        OP_NEW_TABLE: begin
          valid = 1; used = 0; add_status(ST_OK, '0);
        end
        OP_APPEND: begin
          if (!valid) add_status(ST_INVALID, '0);
          else if (used >= NEXT) add_status(ST_FULL, '0);
          else begin
            ext_start[used] = q.extent_start;
            ext_len[used]   = q.extent_length;
            ext_src[used]   = q.extent_source;
            ext_layer[used] = q.extent_layer;
            ext_zero[used]  = q.extent_is_zero;
            used++;
            add_status(ST_OK, '0);
          end
        end
        default: begin
          ofs = q.read_offset;
          cnt = q.read_bytes;
          if (ofs % SECB != 0 || cnt % SECB != 0) begin
            add_status(ST_MISALIGNED, '0); return;
          end
          if (ofs >= vsize) begin add_status(ST_OK, '0); return; end
          if (cnt > vsize - ofs) cnt = vsize - ofs;
          if (cnt == 0) begin add_status(ST_OK, '0); return; end
          if (!valid) begin add_status(ST_INVALID, '0); return; end
          ssec = ofs / SECB;
          esec = (ofs + cnt) / SECB;
          it = 0;
          while (it < used && longint'(ext_start[it]) + ext_len[it] <= ssec) it++;
          cur = ssec;
          npieces = 0;
          while (cur < esec) begin
            if (it >= used || ext_start[it] >= esec) begin
              add_piece(KIND_ZERO, cur - ssec, esec - cur, '0, '0);
              npieces++;
              break;
            end
            s = ext_start[it];
            e = s + ext_len[it];
            if (s > cur) begin
              add_piece(KIND_ZERO, cur - ssec, s - cur, '0, '0);
              npieces++;
              cur = s;
              continue;
            end
            if (e <= cur) begin it++; continue; end
            upto = (e < esec) ? e : esec;
            if (ext_zero[it]) add_piece(KIND_ZERO, cur - ssec, upto - cur, '0, '0);
            else add_piece(KIND_SOURCE, cur - ssec, upto - cur, ext_layer[it],
                           ext_src[it] + SRC_W'(cur - s));
            npieces++;
            cur = upto;
            if (e <= cur) it++;
          end
          if (npieces == 0) add_status(ST_OK, cnt[CNT_W-1:0]);
          else begin
            pending[$].total_bytes = cnt[CNT_W-1:0];
            pending[$].last = 1'b1;
          end
        end
      endcase
    endfunction

    // Compare one result with the oldest expected piece.
    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t result mismatch: expected %h actual %h", $realtime, want, got);
        if (got.piece_kind !== want.piece_kind)
          $display("%0t  piece_kind expected %0d actual %0d", $realtime,
                   want.piece_kind, got.piece_kind);
        if (got.dest_sector !== want.dest_sector)
          $display("%0t  dest_sector expected %0d actual %0d", $realtime,
                   want.dest_sector, got.dest_sector);
        if (got.piece_sectors !== want.piece_sectors)
          $display("%0t  piece_sectors expected %0d actual %0d", $realtime,
                   want.piece_sectors, got.piece_sectors);
        if (got.src_layer !== want.src_layer)
          $display("%0t  src_layer expected %0d actual %0d", $realtime,
                   want.src_layer, got.src_layer);
        if (got.src_sector !== want.src_sector)
          $display("%0t  src_sector expected %0d actual %0d", $realtime,
                   want.src_sector, got.src_sector);
        if (got.status !== want.status)
          $display("%0t  status expected %0d actual %0d", $realtime,
                   want.status, got.status);
        if (got.total_bytes !== want.total_bytes)
          $display("%0t  total_bytes expected %0d actual %0d", $realtime,
                   want.total_bytes, got.total_bytes);
        if (got.last !== want.last)
          $display("%0t  last expected %0d actual %0d", $realtime, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  plan_board board;

  // Receiver control: random stall pattern, plus one long hold-off on demand.
  bit hold_req;
  bit hold_busy;
  int unsigned stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sampling at the edge, driving with NBA: no race with the block.
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) board.note_request(req_ch.data);
    if (rst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
  end

  // Receiver ready pattern, runs in its own process.
  initial begin
    int unsigned n;
    res_ch.ready <= 1'b0;
    hold_busy = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off: block fills and must stall its input
        hold_busy = 1;
        res_ch.ready <= 1'b0;
        for (n = 0; n < 300; n++) @(posedge clk);
        hold_busy = 0;
        hold_req = 0;
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one request and wait until it is taken.
  task automatic send_request(req_t q);
    req_ch.valid <= 1'b1;
    req_ch.data  <= q;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic idle_sender(int unsigned cycles);
    int unsigned n;
    req_ch.valid <= 1'b0;
    for (n = 0; n < cycles; n++) @(posedge clk);
  endtask

  // Wait until every expected piece has arrived, then let the walk settle.
  task automatic drain();
    int unsigned n;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0 || hold_busy) @(posedge clk);
    for (n = 0; n < 4 + 2 * (NEXT + 33) + 10; n++) @(posedge clk);
  endtask

  task automatic set_vsize(logic [VSZ_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.vsize = v;
  endtask

  function automatic req_t mk_op(op_t op);
    req_t q;
    q = '0;
    q.op = op;
    return q;
  endfunction

  function automatic req_t mk_ext(longint unsigned st, longint unsigned len,
                                  longint unsigned src, int unsigned lay, bit z);
    req_t q;
    q = mk_op(OP_APPEND);
    q.extent_start  = st[START_W-1:0];
    q.extent_length = len[LEN_W-1:0];
    q.extent_source = src[SRC_W-1:0];
    q.extent_layer  = lay[LAYER_W-1:0];
    q.extent_is_zero = z;
    return q;
  endfunction

  function automatic req_t mk_read(longint unsigned ofs, longint unsigned cnt);
    req_t q;
    q = mk_op(OP_READ);
    q.read_offset = ofs[OFS_W-1:0];
    q.read_bytes  = cnt[CNT_W-1:0];
    return q;
  endfunction

  // Random junk in every field, for bit toggling on unused fields.
  function automatic req_t rand_noise();
    req_t q;
    q.op = $urandom;
    q.extent_start = {$urandom, $urandom};
    q.extent_length = $urandom;
    q.extent_source = {$urandom, $urandom};
    q.extent_layer = $urandom;
    q.extent_is_zero = $urandom;
    q.read_offset = {$urandom, $urandom};
    q.read_bytes = $urandom;
    return q;
  endfunction

  // Sorted table of n random extents with random holes, starting at base.
  task automatic build_table(int unsigned n, longint unsigned base);
    longint unsigned at, len;
    int unsigned k;
    req_t q;
    send_request(mk_op(OP_NEW_TABLE));
    at = base;
    for (k = 0; k < n; k++) begin
      at += $urandom_range(3) == 0 ? 0 : $urandom_range(8);
      len = $urandom_range(5) == 0 ? 0 : $urandom_range(1, 12);
      q = mk_ext(at, len, {$urandom, $urandom}, $urandom_range(255),
                 $urandom_range(3) == 0);
      // keep the unused read fields toggling too
      q.read_offset = {$urandom, $urandom};
      q.read_bytes = $urandom;
      send_request(q);
      at += len;
    end
  endtask

  initial begin
    int unsigned k, sent, burst, b, ns;
    longint unsigned base, sec;
    req_t q;

    board = new();
    board.clear();
    hold_req = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, size 0, every op, every status.
    send_request(mk_read(0, 512));              // beyond size 0
    drain();
    set_vsize('0);
    set_vsize(48'd1 << 20);
    send_request(mk_read(0, 512));              // invalid table
    send_request(mk_ext(0, 4, 7, 1, 0));        // append to invalid table
    send_request(mk_read(3, 512));              // misaligned offset
    send_request(mk_read(512, 100));            // misaligned count
    send_request(mk_read(0, 0));                // zero bytes
    send_request(mk_op(OP_NEW_TABLE));
    send_request(mk_read(0, 4096));             // empty table: one zero fill
    send_request(mk_ext(2, 3, 40'hFF_FFFF_FFFE, 255, 0)); // source wraps
    send_request(mk_ext(5, 0, 1, 2, 0));        // zero length entry
    send_request(mk_ext(8, 4, 9, 3, 1));        // zeroed extent
    send_request(mk_ext(1, 10, 100, 4, 0));     // out of order, overlaps
    send_request(mk_read(0, 20 * 512));
    send_request(mk_read(3 * 512, 8 * 512));
    for (k = 0; k < 13; k++) send_request(mk_ext(30 + 2 * k, 1, k, k, k[0]));
    send_request(mk_ext(100, 1, 1, 1, 0));      // table full
    send_request(mk_read(0, 32'hFFFF_FE00));    // clipped to size, many pieces
    send_request(mk_op(OP_INVALIDATE));
    send_request(mk_read(0, 512));
    drain();

    // Unaligned size: tail below one sector gets no piece.
    set_vsize(48'd700);
    send_request(mk_op(OP_NEW_TABLE));
    send_request(mk_ext(0, 1, 5, 6, 0));
    send_request(mk_read(0, 1024));
    send_request(mk_read(512, 512));            // clipped to 188 bytes, no piece
    drain();

    // Largest size, reads near the top of the space.
    set_vsize({VSZ_W{1'b1}});
    send_request(mk_op(OP_NEW_TABLE));
    send_request(mk_ext(39'h7F_FFFF_FFF0, 32'hFFFF_FFFF, 0, 9, 0));
    send_request(mk_read(48'hFFFF_FFFF_E000, 32'hFFFF_FE00));
    send_request(mk_read(48'hFFFF_FFFF_FE00, 512));
    drain();

    // Pressure: receiver holds off while the sender keeps offering.
    set_vsize(48'd1 << 24);
    hold_req = 1;
    build_table(NEXT, 0);
    for (k = 0; k < 6; k++) send_request(mk_read(0, 64 * 512));
    drain();

    // Random phase: mostly well formed tables and aligned reads.
    sent = 0;
    while (sent < 160) begin
      case ($urandom_range(3))
        0: set_vsize(48'd1 << 18);
        1: set_vsize({$urandom_range(2000), 9'd0} + $urandom_range(1) * 100);
        2: set_vsize({VSZ_W{1'b1}});
        default: set_vsize($urandom_range(1) ? 48'd0 : 48'd40960);
      endcase
      stall_pct = $urandom_range(3) == 0 ? 0 : $urandom_range(70);
      base = $urandom_range(1) ? 0 : {$urandom_range(3), 9'd0};
      ns = $urandom_range(NEXT + 2);
      if ($urandom_range(5) == 0) send_request(mk_op(OP_INVALIDATE));
      else build_table(ns, base);
      sent += ns + 1;
      burst = 0;
      for (b = 0; b < 10; b++) begin
        if (burst == 0) begin
          idle_sender($urandom_range(6));
          burst = $urandom_range(1, 6);
        end
        burst--;
        k = $urandom_range(9);
        if (k == 0) q = rand_noise();
        else if (k == 1) q = mk_read({$urandom, $urandom}, $urandom);
        else begin
          sec = base + $urandom_range(200);
          if (board.vsize == {VSZ_W{1'b1}} && $urandom_range(3) == 0)
            sec = (48'hFFFF_FFFF_FFFF / SECB) - $urandom_range(300);
          q = mk_read(sec * SECB, $urandom_range(1, 150) * SECB);
        end
        if (q.op == OP_APPEND) q.op = OP_READ; // keep table well formed
        send_request(q);
        sent++;
      end
      drain();
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
